[rtl/clb_pkg.sv]
// Shared types, character codes and the per-byte decision function of the comment blanker.
package clb_pkg;

    // Character codes the scanner looks for
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_DQUOTE = 8'd34;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_CODE  = 3'd0,
        MODE_LINE  = 3'd1,
        MODE_BLOCK = 3'd2,
        MODE_STR   = 3'd3,
        MODE_CHR   = 3'd4
    } mode_t;

    // One output queue entry
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } entry_t;

    // Outcome of deciding one byte
    typedef struct packed {
        logic [7:0] out_byte;
        mode_t      mode;
        logic       claim;
    } decide_t;

    // Decide byte c in the given mode, with one byte of lookahead
    function automatic decide_t clb_decide(mode_t mode, logic [7:0] c, logic [7:0] nxt,
                                           logic has_next);
        decide_t r;
        logic    n_slash;
        logic    n_star;
        n_slash    = has_next && (nxt == CH_SLASH);
        n_star     = has_next && (nxt == CH_STAR);
        r.out_byte = CH_SPACE;
        r.mode     = mode;
        r.claim    = 1'b0;
        unique case (mode) inside
            MODE_LINE: begin
                if (c == CH_NL) begin
                    r.mode     = MODE_CODE;
                    r.out_byte = c;
                end
            end
            MODE_BLOCK: begin
                // star then slash closes; the slash is claimed and blanked
                if (c == CH_STAR && n_slash) begin
                    r.claim = 1'b1;
                    r.mode  = MODE_CODE;
                end else if (c == CH_NL) begin
                    r.out_byte = c;
                end
            end
            MODE_STR, MODE_CHR: begin
                if (c == CH_BSLASH) begin
                    r.claim = has_next;
                end else if ((mode == MODE_STR && c == CH_DQUOTE) ||
                             (mode == MODE_CHR && c == CH_SQUOTE)) begin
                    r.mode     = MODE_CODE;
                    r.out_byte = c;
                end
            end
            default: begin
                r.mode     = MODE_CODE;
                r.out_byte = c;
                if (c == CH_SLASH && n_slash) begin
                    r.mode     = MODE_LINE;
                    r.out_byte = CH_SPACE;
                end else if (c == CH_SLASH && n_star) begin
                    r.mode     = MODE_BLOCK;
                    r.out_byte = CH_SPACE;
                end else if (c == CH_DQUOTE) begin
                    r.mode = MODE_STR;
                end else if (c == CH_SQUOTE) begin
                    r.mode = MODE_CHR;
                end
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/comment_literal_blanker_core.sv]
// Top level of the comment and literal blanker: byte scanner and three-entry output queue.
//
// Takes C/C++ source one byte per stream transaction and returns a stream of the same length
// in which comment bytes and string/char literal contents are replaced by spaces; newlines in
// comments and the quote marks of literals are kept. Each byte is held until the next one
// arrives, so its result appears one input transaction later, and the byte marked by tlast
// releases the held byte's result, if any, and then its own with tlast set; after it the
// scanner starts the next text in code mode. One byte is accepted per clock while the output
// side keeps up. Results wait in a three-entry output queue. s_tready is high while that
// queue holds at most one entry, or two entries when the head leaves in the same cycle, so
// bytes follow back to back, tlast bytes included, when the output is drained at one per
// clock. A result is registered in the output queue and is visible on the master side at
// the earliest in the cycle after the transaction that produces it.
module comment_literal_blanker_core
    import clb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    // scanner state
    mode_t      mode_reg, mode_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       held_consumed_reg, held_consumed_next;

    // output queue, entry 0 is the head
    entry_t     q_reg [3];
    entry_t     q_next [3];
    logic [1:0] count_reg, count_next;

    logic       s_accept;
    logic       pop;
    logic [1:0] base;
    logic [1:0] push_cnt;
    entry_t     push0, push1;
    decide_t    d_held, d_last;
    mode_t      mode_mid;
    logic       claim_b;
    entry_t     res_held, res_last;

    assign s_tready = (count_reg <= 2'd1) || ((count_reg == 2'd2) && m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tlast  = q_reg[0].last;
    assign pop      = m_tvalid && m_tready;

    // decide the held byte with the new byte as lookahead, then the new byte at end of text
    always_comb begin
        d_held   = clb_decide(mode_reg, held_byte_reg, s_tdata, 1'b1);
        mode_mid = mode_reg;
        claim_b  = 1'b0;
        res_held.data = CH_SPACE;
        res_held.last = 1'b0;
        if (held_valid_reg && !held_consumed_reg) begin
            mode_mid      = d_held.mode;
            claim_b       = d_held.claim;
            res_held.data = d_held.out_byte;
        end
        d_last        = clb_decide(mode_mid, s_tdata, 8'd0, 1'b0);
        res_last.data = claim_b ? CH_SPACE : d_last.out_byte;
        res_last.last = 1'b1;
    end

    // scanner state update
    always_comb begin
        mode_next          = mode_reg;
        held_byte_next     = held_byte_reg;
        held_valid_next    = held_valid_reg;
        held_consumed_next = held_consumed_reg;
        if (s_accept) begin
            if (s_tlast) begin
                mode_next          = MODE_CODE;
                held_byte_next     = 8'd0;
                held_valid_next    = 1'b0;
                held_consumed_next = 1'b0;
            end else begin
                mode_next          = mode_mid;
                held_byte_next     = s_tdata;
                held_valid_next    = 1'b1;
                held_consumed_next = claim_b;
            end
        end
    end

    // results pushed by this transaction
    always_comb begin
        push_cnt = 2'd0;
        push0    = res_held;
        push1    = res_last;
        if (s_accept) begin
            if (held_valid_reg) begin
                push_cnt = s_tlast ? 2'd2 : 2'd1;
            end else begin
                push_cnt = s_tlast ? 2'd1 : 2'd0;
                push0    = res_last;
            end
        end
    end

    // queue: shift out on pop, append after the remaining entries
    always_comb begin
        base      = count_reg - {1'b0, pop};
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = pop ? q_reg[2] : q_reg[1];
        q_next[2] = q_reg[2];
        if (push_cnt != 2'd0) begin
            if (base == 2'd0) q_next[0] = push0;
            if (base == 2'd1) q_next[1] = push0;
            if (base == 2'd2) q_next[2] = push0;
        end
        if (push_cnt == 2'd2) begin
            if (base == 2'd0) q_next[1] = push1;
            if (base == 2'd1) q_next[2] = push1;
        end
        count_next = base + push_cnt;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_CODE;
            held_byte_reg     <= 8'd0;
            held_valid_reg    <= 1'b0;
            held_consumed_reg <= 1'b0;
            count_reg         <= 2'd0;
        end else begin
            mode_reg          <= mode_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            held_consumed_reg <= held_consumed_next;
            count_reg         <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge aclk) begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

endmodule

[rtl/clb_checker.sv]
// Port-level checker for the comment blanker core, with its bind statement.
module clb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled result stays offered
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // the end-of-text transaction always leaves a result to deliver
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after end-of-text transaction");

    // with nothing queued and nothing accepted, no result appears
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared without an input transaction");

    // reset empties the output queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind comment_literal_blanker_core clb_checker u_clb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/clb_scoreboard_pkg.sv]
// Scoreboard for the comment blanker: byte-level predictor and store of expected result bytes.
`timescale 1ns / 1ps

package clb_scoreboard_pkg;
    import clb_pkg::*;

    class blank_scoreboard;
        // predictor state, mirrors the scanner
        mode_t      scan_mode;
        logic [7:0] held_byte;
        bit         held_valid;
        bit         held_claimed;

        entry_t     blanked_q[$];
        int         mismatches;
        int         bytes_in;
        int         bytes_out;
        int         texts;

        function new();
            clear_scan();
            mismatches = 0;
            bytes_in   = 0;
            bytes_out  = 0;
            texts      = 0;
        endfunction

        function void clear_scan();
            scan_mode    = MODE_CODE;
            held_byte    = 8'd0;
            held_valid   = 1'b0;
            held_claimed = 1'b0;
        endfunction

        // Blank or keep byte c, looking ahead at nxt; moves the scan mode on
        function logic [7:0] predict_blank(logic [7:0] c, logic [7:0] nxt, bit has_next,
                                           output bit claim);
            bit next_slash;
            bit next_star;
            next_slash = has_next && (nxt == CH_SLASH);
            next_star  = has_next && (nxt == CH_STAR);
            claim      = 1'b0;
            case (scan_mode)
                MODE_LINE: begin
                    if (c == CH_NL) begin
                        scan_mode = MODE_CODE;
                        return c;
                    end
                    return CH_SPACE;
                end
                MODE_BLOCK: begin
                    // star followed by slash ends the comment, slash blanked too
                    if (c == CH_STAR && next_slash) begin
                        claim     = 1'b1;
                        scan_mode = MODE_CODE;
                        return CH_SPACE;
                    end
                    return (c == CH_NL) ? c : CH_SPACE;
                end
                MODE_STR, MODE_CHR: begin
                    // escape swallows the byte after it
                    if (c == CH_BSLASH) begin
                        claim = has_next;
                        return CH_SPACE;
                    end
                    if ((scan_mode == MODE_STR && c == CH_DQUOTE) ||
                        (scan_mode == MODE_CHR && c == CH_SQUOTE)) begin
                        scan_mode = MODE_CODE;
                        return c;
                    end
                    return CH_SPACE;
                end
                default: begin
                    scan_mode = MODE_CODE;
                    if (c == CH_SLASH && next_slash) begin
                        scan_mode = MODE_LINE;
                        return CH_SPACE;
                    end
                    if (c == CH_SLASH && next_star) begin
                        scan_mode = MODE_BLOCK;
                        return CH_SPACE;
                    end
                    if (c == CH_DQUOTE)
                        scan_mode = MODE_STR;
                    else if (c == CH_SQUOTE)
                        scan_mode = MODE_CHR;
                    return c;
                end
            endcase
        endfunction

        // Accepted input transaction: work out the results it releases
        function void note_input(logic [7:0] b, bit last);
            bit         claim_next;
            bit         unused_claim;
            logic [7:0] o;
            entry_t     e;
            claim_next = 1'b0;
            bytes_in++;
            if (held_valid) begin
                if (held_claimed)
                    o = CH_SPACE;
                else
                    o = predict_blank(held_byte, b, 1'b1, claim_next);
                e.last = 1'b0;
                e.data = o;
                blanked_q.insert(blanked_q.size(), e);
            end
            if (last) begin
                // end of text: no lookahead, then a fresh text in code mode
                if (claim_next)
                    o = CH_SPACE;
                else
                    o = predict_blank(b, 8'd0, 1'b0, unused_claim);
                e.last = 1'b1;
                e.data = o;
                blanked_q.insert(blanked_q.size(), e);
                texts++;
                clear_scan();
            end else begin
                held_byte    = b;
                held_valid   = 1'b1;
                held_claimed = claim_next;
            end
        endfunction

        // Accepted result transaction: compare with the oldest expected byte
        function void check_result(logic [7:0] b, logic last);
            entry_t e;
            bytes_out++;
            if (blanked_q.size() == 0) begin
                $error("unexpected result: out_byte %0d out_last %0d", b, last);
                mismatches++;
                return;
            end
            e = blanked_q.pop_front();
            if (b !== e.data) begin
                $error("out_byte mismatch: expected %0d, actual %0d", e.data, b);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("out_last mismatch: expected %0d, actual %0d", e.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return blanked_q.size();
        endfunction
    endclass

endpackage

[tb/comment_literal_blanker_core_tb.sv]
// Testbench top for the comment and literal blanker: stimulus, stall processes and checks.
`timescale 1ns / 1ps

module comment_literal_blanker_core_tb;
    import clb_pkg::*;
    import clb_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 60;
    localparam int ITEMS_PER_PHASE = 300;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    blank_scoreboard sb;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req      = 1'b0;
    int         idle_cycles   = 0;
    logic [7:0] text_q[$];

    comment_literal_blanker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // Watchdog: cycles with no transaction on either side
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[comment_literal_blanker_core] ERROR");
        $finish;
    end

    // Append one byte to the text being built
    function automatic void add_byte(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    // One input transaction, entered and left at a falling edge
    task automatic send_byte(logic [7:0] b, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, last);
        @(negedge aclk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_str(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
        send_text();
    endtask

    // Sender stops until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // Byte for comment or literal bodies, biased towards the special characters
    function automatic logic [7:0] body_char();
        case ($urandom_range(9))
            0: return CH_NL;
            1: return CH_STAR;
            2: return CH_SLASH;
            3: return CH_DQUOTE;
            4: return CH_SQUOTE;
            5: return CH_BSLASH;
            6: return 8'($urandom_range(255));
            7: return CH_SPACE;
            default: return 8'($urandom_range(8'h61, 8'h7a));
        endcase
    endfunction

    // String body byte that neither ends nor escapes
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = body_char();
        while (c == CH_DQUOTE || c == CH_BSLASH) c = body_char();
        return c;
    endfunction

    function automatic void push_token();
        int         kind;
        int         n;
        logic [7:0] c;
        kind = $urandom_range(99);
        n    = $urandom_range(0, 6);
        if (kind < 15) begin
            // noise: raw bytes or stray markers
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(1))
                    add_byte(8'($urandom_range(255)));
                else
                    add_byte(body_char());
            end
        end else if (kind < 35) begin
            repeat (n + 1) begin
                case ($urandom_range(5))
                    0: c = CH_SPACE;
                    1: c = CH_NL;
                    2: c = 8'h3b;
                    3: c = 8'($urandom_range(8'h30, 8'h39));
                    default: c = 8'($urandom_range(8'h41, 8'h7a));
                endcase
                add_byte(c);
            end
        end else if (kind < 50) begin
            push_str("//");
            repeat (n) add_byte(body_char());
            if ($urandom_range(4) != 0) add_byte(CH_NL);
        end else if (kind < 65) begin
            push_str("/*");
            repeat (n) add_byte(body_char());
            if ($urandom_range(5) != 0) push_str("*/");
        end else if (kind < 70) begin
            push_str("/*/");
        end else if (kind < 85) begin
            add_byte(CH_DQUOTE);
            repeat (n) begin
                if ($urandom_range(4) == 0) begin
                    add_byte(CH_BSLASH);
                    add_byte(body_char());
                end else begin
                    add_byte(plain_char());
                end
            end
            if ($urandom_range(5) != 0) add_byte(CH_DQUOTE);
        end else begin
            add_byte(CH_SQUOTE);
            if ($urandom_range(2) == 0) add_byte(CH_BSLASH);
            add_byte(body_char());
            if ($urandom_range(5) != 0) add_byte(CH_SQUOTE);
        end
    endfunction

    // A text is a handful of tokens; now and then a single byte
    function automatic void build_text();
        text_q.delete();
        if ($urandom_range(9) == 0)
            add_byte(8'($urandom_range(255)));
        else
            repeat ($urandom_range(1, 6)) push_token();
    endfunction

    task automatic run_random(int n_items);
        int stop_at;
        stop_at = sb.bytes_in + n_items;
        while (sb.bytes_in < stop_at) begin
            build_text();
            send_text();
        end
    endtask

    // Main sequence
    initial begin
        sb = new();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // phase one: sender idles a quarter, receiver mostly stalled
        send_idle_pct = 25;
        recv_idle_pct = 78;

        // directed: lone slash at end of text, line comment ended by newline
        send_str("/");
        send_str("//x\ny");
        // block comment with a kept newline, then the self-closing opener
        send_str("/*\n*/");
        send_str("/*/z");
        // escaped quote in a string, backslash as the final byte of a char literal
        send_str("\"\\\"'\"");
        send_str("'\\");
        // byte extremes
        text_q.delete();
        add_byte(8'hff);
        add_byte(8'h00);
        send_text();

        run_random(ITEMS_PER_PHASE);
        wait_drained();

        // phase two: roles swapped
        send_idle_pct = 78;
        recv_idle_pct = 25;
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        // phase three: no idling, with one long output hold-off up front
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_random(ITEMS_PER_PHASE);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Run covered %0d texts: %0d source bytes in, %0d blanked bytes out,",
                 sb.texts, sb.bytes_in, sb.bytes_out);
        $display("over three stall mixes, a long output hold-off and drain pauses.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[comment_literal_blanker_core] OK");
        else
            $display("[comment_literal_blanker_core] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/clb_pkg.sv
rtl/comment_literal_blanker_core.sv
rtl/clb_checker.sv
tb/clb_scoreboard_pkg.sv
tb/comment_literal_blanker_core_tb.sv
